// ===== rtl/core/sas_pkg.sv =====
`timescale 1ns / 1ps

package sas_pkg;

  localparam int MAX_BLOCKS      = 16;
  localparam int SLOTS_PER_BLOCK = 8;
  localparam int BLK_W           = $clog2(MAX_BLOCKS);
  localparam int SLOT_W          = $clog2(SLOTS_PER_BLOCK);
  localparam int CNT_W           = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int NBLK_W          = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W          = BLK_W + SLOT_W;
  localparam int STACK_DEPTH     = MAX_BLOCKS * SLOTS_PER_BLOCK;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    BK_EXEC = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } rsp_t;

endpackage

// ===== rtl/core/sas_front.sv =====
`timescale 1ns / 1ps

module sas_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       cmd,
  input  logic [sas_pkg::BLK_W-1:0]  release_block,
  input  logic [sas_pkg::SLOT_W-1:0] release_slot,
  output logic                       q_valid,
  input  logic                       q_ready,
  output sas_pkg::req_t              q_item
);
  import sas_pkg::*;

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  req_t              incoming;
  logic              push;
  logic              pop;

  always_comb begin
    incoming.blk  = release_block;
    incoming.slot = release_slot;
    unique case (cmd)
      1'b0: incoming.op = OP_ACQUIRE;
      1'b1: incoming.op = OP_RELEASE;
      default: incoming.op = OP_ACQUIRE;
    endcase
  end

  assign req_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count != '0);
  assign q_item    = entries[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sas_back.sv =====
`timescale 1ns / 1ps

module sas_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  sas_pkg::req_t q_item,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sas_pkg::rsp_t rsp
);
  import sas_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(SLOTS_PER_BLOCK - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS_PER_BLOCK);
  localparam logic [NBLK_W-1:0] NBLK_FULL = NBLK_W'(MAX_BLOCKS);

  back_state_t       state;
  back_state_t       state_next;

  logic [CNT_W-1:0]  slots_left [MAX_BLOCKS];
  // Stack positions below the low mark still hold their creation value,
  // so a new block needs no fill pass through the stack memory.
  logic [CNT_W-1:0]  low_mark   [MAX_BLOCKS];
  logic [NBLK_W-1:0] blocks_created;
  logic [SLOT_W-1:0] stack_mem  [STACK_DEPTH];
  logic [SLOT_W-1:0] rd_data;

  logic [BLK_W-1:0]  acq_blk;
  logic [SLOT_W-1:0] acq_pos;
  logic              acq_init;

  logic [MAX_BLOCKS-1:0] nonempty;
  logic              hint_found;
  logic [BLK_W-1:0]  hint_idx;

  logic              space;
  logic              fc_we;
  logic [BLK_W-1:0]  fc_idx;
  logic [CNT_W-1:0]  fc_wdata;
  logic              lw_we;
  logic [CNT_W-1:0]  lw_wdata;
  logic              create;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic              latch_acq;
  logic [SLOT_W-1:0] acq_pos_next;
  logic              acq_init_next;
  logic              rsp_load;
  rsp_t              rsp_next;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_dec;

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      nonempty[i] = (slots_left[i] != '0);
    end
  end

  // The lowest block with free slots is the allocation hint.
  always_comb begin
    hint_found = 1'b0;
    hint_idx   = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        hint_found = 1'b1;
        hint_idx   = BLK_W'(i);
      end
    end
  end

  assign space = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_EXEC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    q_ready       = 1'b0;
    fc_we         = 1'b0;
    fc_idx        = q_item.blk;
    fc_wdata      = '0;
    lw_we         = 1'b0;
    lw_wdata      = CNT_FULL;
    create        = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    latch_acq     = 1'b0;
    acq_pos_next  = '0;
    acq_init_next = 1'b0;
    rsp_load      = 1'b0;
    rsp_next.blk    = '0;
    rsp_next.slot   = '0;
    rsp_next.status = ST_OK;
    cnt_cur       = slots_left[fc_idx];
    cnt_dec       = '0;
    unique case (state)
      BK_EXEC: begin
        if (q_valid && space) begin
          q_ready = 1'b1;
          unique case (q_item.op)
            OP_ACQUIRE: begin
              if (hint_found) begin
                fc_idx        = hint_idx;
                cnt_cur       = slots_left[hint_idx];
                cnt_dec       = cnt_cur - CNT_W'(1);
                fc_we         = 1'b1;
                fc_wdata      = cnt_dec;
                latch_acq     = 1'b1;
                acq_pos_next  = cnt_dec[SLOT_W-1:0];
                acq_init_next = (cnt_dec < low_mark[hint_idx]);
                mem_re        = 1'b1;
                mem_addr      = {hint_idx, cnt_dec[SLOT_W-1:0]};
                state_next    = BK_READ;
              end else if (blocks_created >= NBLK_FULL) begin
                rsp_load        = 1'b1;
                rsp_next.status = ST_EXHAUSTED;
              end else begin
                // Create the next block and pop its top entry at once.
                fc_idx        = blocks_created[BLK_W-1:0];
                fc_we         = 1'b1;
                fc_wdata      = CNT_FULL - CNT_W'(1);
                lw_we         = 1'b1;
                lw_wdata      = CNT_FULL;
                create        = 1'b1;
                latch_acq     = 1'b1;
                acq_pos_next  = SLOT_MAX;
                acq_init_next = 1'b1;
                state_next    = BK_READ;
              end
            end
            OP_RELEASE: begin
              rsp_load = 1'b1;
              if ({1'b0, q_item.blk} >= blocks_created || cnt_cur == CNT_FULL) begin
                rsp_next.status = ST_BAD_RELEASE;
              end else begin
                fc_we    = 1'b1;
                fc_wdata = cnt_cur + CNT_W'(1);
                mem_we   = 1'b1;
                mem_addr = {q_item.blk, cnt_cur[SLOT_W-1:0]};
                if (cnt_cur < low_mark[q_item.blk]) begin
                  lw_we    = 1'b1;
                  lw_wdata = cnt_cur;
                end
              end
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        if (space) begin
          rsp_load        = 1'b1;
          rsp_next.blk    = acq_blk;
          rsp_next.slot   = acq_init ? (SLOT_MAX - acq_pos) : rd_data;
          rsp_next.status = ST_OK;
          state_next      = BK_EXEC;
        end
      end
      default: begin
        state_next = BK_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_addr] <= q_item.slot;
    end
    if (mem_re) begin
      rd_data <= stack_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_we) begin
      low_mark[fc_idx] <= lw_wdata;
    end
    if (latch_acq) begin
      acq_blk  <= fc_idx;
      acq_pos  <= acq_pos_next;
      acq_init <= acq_init_next;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        slots_left[i] <= '0;
      end
      blocks_created <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (fc_we) begin
        slots_left[fc_idx] <= fc_wdata;
      end
      if (create) begin
        blocks_created <= blocks_created + NBLK_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/slab_slot_allocator.sv =====
`timescale 1ns / 1ps

// Slot allocator over up to sixteen blocks of eight slots, with one result
// transfer for every request transfer, in order. Requests enter a two-entry
// queue and are carried out one at a time by the execution stage: a release
// or an exhausted acquire finishes there, and any other acquire passes on to
// a read state, because the free-slot stack memory has a registered read
// port. The lowest block with free slots is found each cycle from per-block
// free counts, and a newly created block needs no fill of the stack memory,
// so there is no clearing pass after reset. A full result register lets the
// queue keep taking requests while a result waits.
module slab_slot_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       cmd,
  input  logic [sas_pkg::BLK_W-1:0]  release_block,
  input  logic [sas_pkg::SLOT_W-1:0] release_slot,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [sas_pkg::BLK_W-1:0]  granted_block,
  output logic [sas_pkg::SLOT_W-1:0] granted_slot,
  output logic [1:0]                 status
);
  import sas_pkg::*;

  logic q_valid;
  logic q_ready;
  req_t q_item;
  rsp_t rsp;

  sas_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .cmd           (cmd),
    .release_block (release_block),
    .release_slot  (release_slot),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  sas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign granted_block = rsp.blk;
  assign granted_slot  = rsp.slot;
  assign status        = rsp.status;

endmodule
